// ----- hw/rtl/jre_pkg.sv -----
package jre_pkg;

    // Field widths of the input and result words.
    localparam int KIND_W        = 2;
    localparam int STEPS_W       = 16;
    localparam int REPORT_W      = 3;
    localparam int ENTRY_W       = 6;
    localparam int REMAIN_W      = 7;
    localparam int RING_SIZE_W   = 7;
    localparam int RING_SIZE_RST = 64;

    // Operation codes carried by an input word.
    typedef enum logic [KIND_W-1:0] {
        KIND_REMOVE_FWD = 2'd0,
        KIND_REMOVE_BWD = 2'd1,
        KIND_LIST       = 2'd2,
        KIND_REBUILD    = 2'd3
    } kind_t;

    // Report codes carried by a result word.
    typedef enum logic [REPORT_W-1:0] {
        RPT_REMOVED = 3'd0,
        RPT_LISTED  = 3'd1,
        RPT_EMPTY   = 3'd2,
        RPT_ERROR   = 3'd3,
        RPT_REBUILT = 3'd4
    } report_kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [STEPS_W-1:0]   steps;
    } in_word_t;

    typedef struct packed {
        report_kind_t         report_kind;
        logic [ENTRY_W-1:0]   entry;
        logic [REMAIN_W-1:0]  remaining;
        logic                 last;
    } out_word_t;

endpackage

// ----- hw/rtl/jre_link_mem.sv -----
module jre_link_mem
    import jre_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] rd_next,
    output logic [IDX_W-1:0] rd_prev,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_next_addr,
    input  logic [IDX_W-1:0] wr_next_data,
    input  logic [IDX_W-1:0] wr_prev_addr,
    input  logic [IDX_W-1:0] wr_prev_data
);

    logic [IDX_W-1:0] next_mem [DEPTH];
    logic [IDX_W-1:0] prev_mem [DEPTH];
    logic [IDX_W-1:0] rd_next_reg;
    logic [IDX_W-1:0] rd_prev_reg;

    // Both link tables share one read address; read data is held until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            next_mem[wr_next_addr] <= wr_next_data;
            prev_mem[wr_prev_addr] <= wr_prev_data;
        end
        if (rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;

endmodule

// ----- hw/rtl/jre_mod_unit.sv -----
module jre_mod_unit
    import jre_pkg::*;
#(
    parameter int DIV_W = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [STEPS_W-1:0] dividend,
    input  logic [DIV_W-1:0]   divisor,
    output logic               done,
    output logic [DIV_W-1:0]   rem
);

    localparam int CNT_W = $clog2(STEPS_W);

    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STEPS_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     trial_sub;

    // One restoring remainder step per cycle, most significant dividend bit first.
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        trial       = {rem_reg, dvd_reg[STEPS_W-1]};
        trial_sub   = trial - {1'b0, divisor};
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(STEPS_W - 1);
            dvd_next    = dividend;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = (trial >= {1'b0, divisor}) ? DIV_W'(trial_sub) : DIV_W'(trial);
            dvd_next = {dvd_reg[STEPS_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/josephus_ring_eliminator_core.sv -----
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | in_word_t  (kind, steps)
// out     | output    | out_valid / out_ready| out_word_t (report_kind, entry, remaining, last)
// cfg     | input     | cfg_valid / cfg_ready| ring_size, used at the next rebuild
//
// Removal reduces steps-1 modulo live_count in the 16-step serial remainder unit, then
// does one link-table read per cycle along the ring, the unlink and the reply.
// Listing does one link read per word; rebuild writes one link-table row per cycle.
// After reset a sweep over all MAX_ENTRIES rows builds the ring, with in_ready low.
// A stalled output holds the list walk in place; in_ready rises once the last word is loaded.
module josephus_ring_eliminator_core
    import jre_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RING_SIZE_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MOD,
        S_WALK,
        S_STEP,
        S_UNLINK,
        S_LIST,
        S_REPLY
    } state_t;

    state_t                 state_reg, state_next;
    logic [RING_SIZE_W-1:0] ring_size_reg, ring_size_next;
    logic [CW-1:0]          live_reg, live_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic [IW-1:0]          c_reg, c_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   fwd_reg, fwd_next;
    logic                   build_reply_reg, build_reply_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_word_reg, out_word_next;
    out_word_t              pend_reg, pend_next;

    logic                   out_free;
    logic [CW-1:0]          ring_sat;
    logic [CW-1:0]          idx_plus;
    logic [IW-1:0]          step_link;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          rd_next;
    logic [IW-1:0]          rd_prev;
    logic                   wr_en;
    logic [IW-1:0]          wr_next_addr;
    logic [IW-1:0]          wr_next_data;
    logic [IW-1:0]          wr_prev_addr;
    logic [IW-1:0]          wr_prev_data;

    logic                   mod_start;
    logic                   mod_done;
    logic [CW-1:0]          mod_rem;

    jre_link_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IW)
    ) u_link_mem (
        .clk          (clk),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_next      (rd_next),
        .rd_prev      (rd_prev),
        .wr_en        (wr_en),
        .wr_next_addr (wr_next_addr),
        .wr_next_data (wr_next_data),
        .wr_prev_addr (wr_prev_addr),
        .wr_prev_data (wr_prev_data)
    );

    jre_mod_unit #(
        .DIV_W (CW)
    ) u_mod_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (in_data.steps - STEPS_W'(1)),
        .divisor  (live_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Ring size clipped to the table depth.
    assign ring_sat = (ring_size_reg > RING_SIZE_W'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                                  : CW'(ring_size_reg);
    assign idx_plus  = CW'(c_reg) + CW'(1);
    assign step_link = fwd_reg ? rd_next : rd_prev;
    assign out_free  = !out_valid_reg || out_ready;

    // Sequencer: rebuild sweep, remainder, link walk, unlink, list walk and replies.
    always_comb
    begin
        state_next       = state_reg;
        ring_size_next   = ring_size_reg;
        live_next        = live_reg;
        cursor_next      = cursor_reg;
        c_next           = c_reg;
        cnt_next         = cnt_reg;
        fwd_next         = fwd_reg;
        build_reply_next = build_reply_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_ready ? 1'b0 : out_valid_reg;
        out_word_next    = out_word_reg;
        rd_en            = 1'b0;
        rd_addr          = c_reg;
        wr_en            = 1'b0;
        wr_next_addr     = c_reg;
        wr_next_data     = '0;
        wr_prev_addr     = c_reg;
        wr_prev_data     = '0;
        mod_start        = 1'b0;

        if (cfg_valid)
        begin
            ring_size_next = cfg_data;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                wr_en        = 1'b1;
                wr_next_data = (idx_plus == live_reg) ? '0 : IW'(idx_plus);
                wr_prev_data = (c_reg == '0) ? IW'(live_reg - CW'(1)) : c_reg - IW'(1);
                c_next       = c_reg + IW'(1);
                if (idx_plus == live_reg)
                begin
                    c_next = '0;
                    if (build_reply_reg)
                    begin
                        pend_next  = '{RPT_REBUILT, '0, REMAIN_W'(live_reg), 1'b1};
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.kind) inside
                        KIND_REBUILD:
                        begin
                            live_next        = ring_sat;
                            cursor_next      = '0;
                            c_next           = '0;
                            build_reply_next = 1'b1;
                            if (ring_sat == '0)
                            begin
                                pend_next  = '{RPT_REBUILT, '0, '0, 1'b1};
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (live_reg == '0)
                            begin
                                pend_next  = '{RPT_EMPTY, '0, '0, 1'b1};
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cursor_reg;
                                c_next     = cursor_reg;
                                cnt_next   = '0;
                                state_next = S_LIST;
                            end
                        end
                        KIND_REMOVE_FWD, KIND_REMOVE_BWD:
                        begin
                            fwd_next = (in_data.kind == KIND_REMOVE_FWD);
                            if (live_reg == '0 || in_data.steps == '0)
                            begin
                                pend_next  = '{RPT_ERROR, '0, REMAIN_W'(live_reg), 1'b1};
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    cnt_next   = mod_rem;
                    c_next     = cursor_reg;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                rd_en      = 1'b1;
                state_next = (cnt_reg == '0) ? S_UNLINK : S_STEP;
            end

            S_STEP:
            begin
                // Follow one link per cycle, reading ahead at the entry just reached.
                rd_en    = 1'b1;
                rd_addr  = step_link;
                c_next   = step_link;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_UNLINK;
                end
            end

            S_UNLINK:
            begin
                // Both neighbours are in the read data: splice them together.
                wr_en        = 1'b1;
                wr_next_addr = rd_prev;
                wr_next_data = rd_next;
                wr_prev_addr = rd_next;
                wr_prev_data = rd_prev;
                live_next    = live_reg - CW'(1);
                if (live_reg == CW'(1))
                begin
                    cursor_next = c_reg;
                end
                else
                begin
                    cursor_next = step_link;
                end
                pend_next  = '{RPT_REMOVED, ENTRY_W'(c_reg),
                               REMAIN_W'(live_reg - CW'(1)), 1'b1};
                state_next = S_REPLY;
            end

            S_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{RPT_LISTED, ENTRY_W'(c_reg), REMAIN_W'(live_reg),
                                       (CW'(cnt_reg + CW'(1)) == live_reg)};
                    if (CW'(cnt_reg + CW'(1)) == live_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_next;
                        c_next   = rd_next;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            ring_size_reg   <= RING_SIZE_W'(RING_SIZE_RST);
            live_reg        <= CW'(MAX_ENTRIES);
            cursor_reg      <= '0;
            c_reg           <= '0;
            cnt_reg         <= '0;
            fwd_reg         <= 1'b0;
            build_reply_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            pend_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ring_size_reg   <= ring_size_next;
            live_reg        <= live_next;
            cursor_reg      <= cursor_next;
            c_reg           <= c_next;
            cnt_reg         <= cnt_next;
            fwd_reg         <= fwd_next;
            build_reply_reg <= build_reply_next;
            out_valid_reg   <= out_valid_next;
            out_word_reg    <= out_word_next;
            pend_reg        <= pend_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // The live count never exceeds the table depth.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MAX_ENTRIES))
        else $error("live count above table depth");

    // The link tables are only written by the sweep or by an unlink.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SWEEP || state_reg == S_UNLINK))
        else $error("link write outside sweep or unlink");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder finished outside its wait state");

    // A link step always has at least one move left.
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> cnt_reg != '0)
        else $error("link step with no moves left");

    // A result word is never overwritten while it waits.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_word_reg))
        else $error("waiting result word changed");

endmodule
